### sv/gbi_pkg.sv
// Shared types and constants of the grid bilinear interpolator.
package gbi_pkg;

  localparam int VW      = 32;
  localparam int MAX_X   = 64;
  localparam int MAX_Y   = 64;
  localparam int XAW     = $clog2(MAX_X);
  localparam int YAW     = $clog2(MAX_Y);
  localparam int ZAW     = XAW + YAW;
  localparam int PTS_W   = 7;
  localparam int FW      = 17;
  localparam int QW      = 16;
  localparam int DW      = VW + 2;
  localparam int ACC_W   = 50;

  typedef enum logic [1:0] {
    KIND_LOAD_X = 2'd0,
    KIND_LOAD_Y = 2'd1,
    KIND_LOAD_Z = 2'd2,
    KIND_QUERY  = 2'd3
  } kind_t;

  localparam logic CFG_X_POINTS = 1'b0;
  localparam logic CFG_Y_POINTS = 1'b1;

  typedef struct packed {
    kind_t                kind;
    logic [5:0]           grid_index;
    logic [5:0]           table_row;
    logic [5:0]           table_col;
    logic signed [VW-1:0] load_value;
    logic signed [VW-1:0] query_x;
    logic signed [VW-1:0] query_y;
  } item_t;

  function automatic logic [PTS_W-1:0] clamp_points(input logic [PTS_W-1:0] n,
                                                    input logic [PTS_W-1:0] mx);
    logic [PTS_W-1:0] r;
    r = n;
    if (n < PTS_W'(2)) r = PTS_W'(2);
    else if (n > mx) r = mx;
    return r;
  endfunction

endpackage

### sv/gbi_front.sv
// Front end: accepts items and holds them in a short queue for the back end.
module gbi_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [1:0]                 kind,
  input  logic [5:0]                 grid_index,
  input  logic [5:0]                 table_row,
  input  logic [5:0]                 table_col,
  input  logic signed [31:0]         load_value,
  input  logic signed [31:0]         query_x,
  input  logic signed [31:0]         query_y,
  output logic                       busy,
  output gbi_pkg::item_t             head,
  output logic                       head_valid,
  input  logic                       pop
);
  import gbi_pkg::*;

  localparam int QD  = 4;
  localparam int QAW = $clog2(QD);

  item_t            queue [QD];
  logic [QAW-1:0]   wr_ptr;
  logic [QAW-1:0]   rd_ptr;
  logic [QAW:0]     count;
  logic             push;
  item_t            item_in;

  assign busy       = (count == (QAW+1)'(QD));
  assign push       = start && !busy;
  assign head_valid = (count != '0);
  assign head       = queue[rd_ptr];

  always_comb begin
    item_in.kind       = kind_t'(kind);
    item_in.grid_index = grid_index;
    item_in.table_row  = table_row;
    item_in.table_col  = table_col;
    item_in.load_value = load_value;
    item_in.query_x    = query_x;
    item_in.query_y    = query_y;
  end

  always_ff @(posedge clk) begin
    if (push) queue[wr_ptr] <= item_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QAW'(1);
      if (pop)  rd_ptr <= rd_ptr + QAW'(1);
      case ({push, pop})
        2'b10:   count <= count + (QAW+1)'(1);
        2'b01:   count <= count - (QAW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

### sv/gbi_div.sv
// Restoring bit-serial divider for Q0.16 fractions; numerator below denominator.
module gbi_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [gbi_pkg::DW-1:0]    num,
  input  logic [gbi_pkg::DW-1:0]    den,
  output logic                      done,
  output logic [gbi_pkg::QW-1:0]    quot
);
  import gbi_pkg::*;

  logic [DW-1:0]         rem;
  logic [DW-1:0]         dvs;
  logic [DW-1:0]         r2;
  logic [$clog2(QW)-1:0] cnt;
  logic                  running;

  assign r2 = {rem[DW-2:0], 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '1;
        rem     <= num;
        dvs     <= den;
        quot    <= '0;
      end else if (running) begin
        if (r2 >= dvs) begin
          rem  <= r2 - dvs;
          quot <= {quot[QW-2:0], 1'b1};
        end else begin
          rem  <= r2;
          quot <= {quot[QW-2:0], 1'b0};
        end
        if (cnt == '0) begin
          running <= 1'b0;
          done    <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

endmodule

### sv/gbi_back.sv
// Back end: grid and table stores, cell search, fractions and bilinear blend.
module gbi_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [6:0]             cfg_data,
  input  gbi_pkg::item_t         head,
  input  logic                   head_valid,
  output logic                   pop,
  output logic                   done,
  output logic signed [31:0]     result_value,
  output logic                   in_range
);
  import gbi_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_EV, S_CHECK, S_GRID_A, S_GRID_B, S_GRID_C,
    S_DIV_X, S_WAIT_X, S_DIV_Y, S_WAIT_Y, S_BL_RD,
    S_BL_0, S_BL_1, S_BL_2, S_BL_3, S_BL_4, S_BL_5, S_BL_6
  } state_t;

  state_t                 state;
  logic [PTS_W-1:0]       x_points, y_points;
  logic [PTS_W-1:0]       nx, ny, n_max;

  logic signed [VW-1:0]   x_grid [MAX_X];
  logic signed [VW-1:0]   y_grid [MAX_Y];
  logic signed [VW-1:0]   z_mem  [MAX_X*MAX_Y];
  logic signed [VW-1:0]   x_rd, y_rd, z_rd;
  logic [XAW-1:0]         x_addr;
  logic [YAW-1:0]         y_addr;
  logic [ZAW-1:0]         z_addr;

  logic signed [VW-1:0]   qx, qy, x0, x1, y0, y1, a0, a1;
  logic [XAW-1:0]         scan_i;
  logic [PTS_W-1:0]       cnt;
  logic                   found;
  logic [YAW-1:0]         yj;
  logic [XAW-1:0]         ix, ix1;
  logic [YAW-1:0]         iy, iy1;
  logic [FW-1:0]          tx, ty, wx, wy;
  logic signed [ACC_W-1:0] acc, prod, rnd;
  logic signed [VW-1:0]   rnd_val;
  logic signed [VW-1:0]   mul_a;
  logic [FW-1:0]          mul_w;

  logic signed [VW:0]     f_num, f_den;
  logic                   f_zero, f_full, div_start, div_done;
  logic [QW-1:0]          div_q;
  logic                   in_cell;

  assign nx    = clamp_points(x_points, PTS_W'(MAX_X));
  assign ny    = clamp_points(y_points, PTS_W'(MAX_Y));
  assign n_max = (nx > ny) ? nx : ny;
  assign pop   = (state == S_IDLE) && head_valid;
  assign ix1   = ix + XAW'(1);
  assign iy1   = iy + YAW'(1);
  assign wx    = FW'(65536) - tx;
  assign wy    = FW'(65536) - ty;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_points <= PTS_W'(64);
      y_points <= PTS_W'(64);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_X_POINTS: x_points <= cfg_data;
        CFG_Y_POINTS: y_points <= cfg_data;
        default:      x_points <= x_points;
      endcase
    end
  end

  always_comb begin
    case (state)
      S_GRID_A: begin x_addr = ix;  y_addr = iy;  end
      S_GRID_B: begin x_addr = ix1; y_addr = iy1; end
      default:  begin x_addr = scan_i; y_addr = YAW'(scan_i); end
    endcase
    case (state)
      S_BL_0:  z_addr = {iy, ix1};
      S_BL_1:  z_addr = {iy1, ix};
      S_BL_2:  z_addr = {iy1, ix1};
      default: z_addr = {iy, ix};
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop && head.kind == KIND_LOAD_X) x_grid[head.grid_index[XAW-1:0]] <= head.load_value;
    if (pop && head.kind == KIND_LOAD_Y) y_grid[head.grid_index[YAW-1:0]] <= head.load_value;
    if (pop && head.kind == KIND_LOAD_Z)
      z_mem[{head.table_row[YAW-1:0], head.table_col[XAW-1:0]}] <= head.load_value;
    x_rd <= x_grid[x_addr];
    y_rd <= y_grid[y_addr];
    z_rd <= z_mem[z_addr];
  end

  // Fraction operands: x while the x step runs, y otherwise.
  always_comb begin
    if (state == S_DIV_X) begin
      f_num = {qx[VW-1], qx} - {x0[VW-1], x0};
      f_den = {x1[VW-1], x1} - {x0[VW-1], x0};
    end else begin
      f_num = {y0[VW-1], y0} - {qy[VW-1], qy};
      f_den = {y0[VW-1], y0} - {y1[VW-1], y1};
    end
    f_zero    = f_den[VW] || (f_den == '0) || f_num[VW] || (f_num == '0);
    f_full    = (f_num >= f_den);
    div_start = ((state == S_DIV_X) || (state == S_DIV_Y)) && !f_zero && !f_full;
  end

  gbi_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   ({1'b0, f_num}),
    .den   ({1'b0, f_den}),
    .done  (div_done),
    .quot  (div_q)
  );

  always_comb begin
    case (state)
      S_BL_0, S_BL_2: begin mul_a = z_rd; mul_w = wx; end
      S_BL_1, S_BL_3: begin mul_a = z_rd; mul_w = tx; end
      S_BL_4:         begin mul_a = a0;   mul_w = wy; end
      default:        begin mul_a = a1;   mul_w = ty; end
    endcase
  end

  assign prod    = mul_a * $signed({1'b0, mul_w});
  assign rnd     = acc + ACC_W'(32768);
  assign rnd_val = rnd[VW+15:16];
  assign in_cell = (cnt >= PTS_W'(1)) && (cnt <= nx - PTS_W'(1)) && found && (yj != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      done         <= 1'b0;
      in_range     <= 1'b0;
      result_value <= '0;
    end else begin
      done         <= 1'b0;
      in_range     <= 1'b0;
      result_value <= '0;
      case (state)
        S_IDLE: begin
          if (pop && head.kind == KIND_QUERY) begin
            qx     <= head.query_x;
            qy     <= head.query_y;
            scan_i <= '0;
            cnt    <= '0;
            found  <= 1'b0;
            state  <= S_SCAN_RD;
          end
        end
        S_SCAN_RD: state <= S_SCAN_EV;
        S_SCAN_EV: begin
          if (({1'b0, scan_i} < nx) && (x_rd <= qx)) cnt <= cnt + PTS_W'(1);
          if (!found && ({1'b0, scan_i} < ny) && (y_rd <= qy)) begin
            found <= 1'b1;
            yj    <= YAW'(scan_i);
          end
          if ({1'b0, scan_i} == n_max - PTS_W'(1)) begin
            state <= S_CHECK;
          end else begin
            scan_i <= scan_i + XAW'(1);
            state  <= S_SCAN_RD;
          end
        end
        S_CHECK: begin
          if (in_cell) begin
            ix    <= XAW'(cnt - PTS_W'(1));
            iy    <= yj - YAW'(1);
            state <= S_GRID_A;
          end else begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_GRID_A: state <= S_GRID_B;
        S_GRID_B: begin
          x0    <= x_rd;
          y0    <= y_rd;
          state <= S_GRID_C;
        end
        S_GRID_C: begin
          x1    <= x_rd;
          y1    <= y_rd;
          state <= S_DIV_X;
        end
        S_DIV_X: begin
          if (f_zero) begin
            tx    <= '0;
            state <= S_DIV_Y;
          end else if (f_full) begin
            tx    <= FW'(65536);
            state <= S_DIV_Y;
          end else begin
            state <= S_WAIT_X;
          end
        end
        S_WAIT_X: begin
          if (div_done) begin
            tx    <= {1'b0, div_q};
            state <= S_DIV_Y;
          end
        end
        S_DIV_Y: begin
          if (f_zero) begin
            ty    <= '0;
            state <= S_BL_RD;
          end else if (f_full) begin
            ty    <= FW'(65536);
            state <= S_BL_RD;
          end else begin
            state <= S_WAIT_Y;
          end
        end
        S_WAIT_Y: begin
          if (div_done) begin
            ty    <= {1'b0, div_q};
            state <= S_BL_RD;
          end
        end
        S_BL_RD: state <= S_BL_0;
        S_BL_0: begin
          acc   <= prod;
          state <= S_BL_1;
        end
        S_BL_1: begin
          acc   <= acc + prod;
          state <= S_BL_2;
        end
        S_BL_2: begin
          a0    <= rnd_val;
          acc   <= prod;
          state <= S_BL_3;
        end
        S_BL_3: begin
          acc   <= acc + prod;
          state <= S_BL_4;
        end
        S_BL_4: begin
          a1    <= rnd_val;
          acc   <= prod;
          state <= S_BL_5;
        end
        S_BL_5: begin
          acc   <= acc + prod;
          state <= S_BL_6;
        end
        S_BL_6: begin
          done         <= 1'b1;
          in_range     <= 1'b1;
          result_value <= rnd_val;
          state        <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### sv/grid_bilinear_interpolator_top.sv
// Top level of the grid bilinear interpolator.
//
// Items enter on start when busy is low: a kind code picks an x grid load,
// a y grid load, a value table load or a query. Items first go into a
// four-deep queue, so start may be given while earlier items still run;
// busy is high only while that queue is full.
// Loads are done in the back end and give no result. A query scans the
// grids one point at a time, a read and an evaluate state per point, over
// the single read port of each grid store, then runs up to two 16-step
// serial divisions and a multiply chain; an out-of-range query ends right
// after the scan. Each query gives one result, shown for one cycle with
// done high; the receiver cannot stall, so none is held. The point counts
// are written through cfg_we/cfg_index/cfg_data; the user must write them
// only while the block is idle, which the block does not enforce. Reset
// empties the queue, sets both counts to 64 and leaves the grid and table
// stores as they are: entries read before they were loaded are undefined.
module grid_bilinear_interpolator_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         kind,
  input  logic [5:0]         grid_index,
  input  logic [5:0]         table_row,
  input  logic [5:0]         table_col,
  input  logic signed [31:0] load_value,
  input  logic signed [31:0] query_x,
  input  logic signed [31:0] query_y,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [6:0]         cfg_data,
  output logic               done,
  output logic signed [31:0] result_value,
  output logic               in_range
);
  import gbi_pkg::*;

  item_t head;
  logic  head_valid;
  logic  pop;

  gbi_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .kind       (kind),
    .grid_index (grid_index),
    .table_row  (table_row),
    .table_col  (table_col),
    .load_value (load_value),
    .query_x    (query_x),
    .query_y    (query_y),
    .busy       (busy),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop)
  );

  gbi_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .head         (head),
    .head_valid   (head_valid),
    .pop          (pop),
    .done         (done),
    .result_value (result_value),
    .in_range     (in_range)
  );

endmodule

### sv/gbi_checker.sv
// Port-level checks of the grid bilinear interpolator, bound to the top level.
module gbi_port_props (
  input logic               clk,
  input logic               rst,
  input logic               busy,
  input logic               done,
  input logic signed [31:0] result_value,
  input logic               in_range
);

  // Every result ends a multi-cycle sequence, so two never come back to back.
  a_done_spaced: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("results in consecutive cycles");

  // An out-of-range query reports a zero value.
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !in_range) |-> (result_value == 32'sd0))
    else $error("out-of-range result with nonzero value");

  // The in-range flag is only shown together with a result.
  a_flag_with_done: assert property (@(posedge clk) in_range |-> done)
    else $error("in_range without a result");

  // The queue starts empty after reset, so busy is low, and no result is shown.
  a_reset_idle: assert property (@(posedge clk) rst |=> (!busy && !done))
    else $error("busy or result right after reset");

endmodule

bind grid_bilinear_interpolator_top gbi_port_props u_checker (
  .clk          (clk),
  .rst          (rst),
  .busy         (busy),
  .done         (done),
  .result_value (result_value),
  .in_range     (in_range)
);

### tb/sv/gbi_checker.sv
// Checker that predicts and compares the results of the grid bilinear interpolator.
`timescale 1ns / 100ps

module gbi_checker
  import gbi_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic [1:0]         kind,
  input  logic [5:0]         grid_index,
  input  logic [5:0]         table_row,
  input  logic [5:0]         table_col,
  input  logic signed [31:0] load_value,
  input  logic signed [31:0] query_x,
  input  logic signed [31:0] query_y,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [6:0]         cfg_data,
  input  logic               done,
  input  logic signed [31:0] result_value,
  input  logic               in_range,
  output int                 errors,
  output int                 pending
);

  typedef struct {
    logic signed [31:0] value;
    logic               hit;
  } interp_t;

  interp_t     interp_q[$];
  longint      x_pts[MAX_X];
  longint      y_pts[MAX_Y];
  longint      z_tab[MAX_X*MAX_Y];
  logic [6:0]  x_count = 7'd64;
  logic [6:0]  y_count = 7'd64;

  initial begin
    errors  = 0;
    pending = 0;
    foreach (x_pts[i]) x_pts[i] = 0;
    foreach (y_pts[i]) y_pts[i] = 0;
    foreach (z_tab[i]) z_tab[i] = 0;
  end

  function automatic longint frac16(longint num, longint den);
    if (den <= 0 || num <= 0) return 0;
    if (num >= den) return 65536;
    return (num <<< 16) / den;
  endfunction

  // Arithmetic shift of a 64-bit value floors, which gives round half up here.
  function automatic longint mix16(longint a, longint b, longint t);
    return (a * (65536 - t) + b * t + 32768) >>> 16;
  endfunction

  function automatic interp_t interpolate(longint qx, longint qy);
    int      nx, ny, ix, iy, cnt, i;
    longint  tx, ty, a0, a1, res;
    interp_t r;
    nx = (x_count < 2) ? 2 : (x_count > MAX_X) ? MAX_X : int'(x_count);
    ny = (y_count < 2) ? 2 : (y_count > MAX_Y) ? MAX_Y : int'(y_count);
    cnt = 0;
    for (i = 0; i < nx; i++) if (x_pts[i] <= qx) cnt++;
    ix = cnt - 1;
    iy = ny - 1;
    for (i = 0; i < ny; i++) begin
      if (y_pts[i] <= qy) begin
        iy = i - 1;
        break;
      end
    end
    r.value = '0;
    r.hit   = 1'b0;
    if (ix < 0 || ix > nx - 2 || iy < 0 || iy > ny - 2) return r;
    tx = frac16(qx - x_pts[ix], x_pts[ix+1] - x_pts[ix]);
    ty = frac16(y_pts[iy] - qy, y_pts[iy] - y_pts[iy+1]);
    a0 = mix16(z_tab[iy*MAX_X + ix], z_tab[iy*MAX_X + ix + 1], tx);
    a1 = mix16(z_tab[(iy+1)*MAX_X + ix], z_tab[(iy+1)*MAX_X + ix + 1], tx);
    res = mix16(a0, a1, ty);
    r.value = res[31:0];
    r.hit   = 1'b1;
    return r;
  endfunction

  always @(posedge clk) begin
    interp_t got, want;
    if (rst) begin
      interp_q.delete();
      x_count = 7'd64;
      y_count = 7'd64;
    end else begin
      if (done) begin
        got.value = result_value;
        got.hit   = in_range;
        if (interp_q.size() == 0) begin
          $display("%0t: unexpected result value %0d in_range %0b", $time, got.value, got.hit);
          errors++;
        end else begin
          want = interp_q.pop_front();
          if (got.value !== want.value) begin
            $display("%0t: result_value mismatch: expected %0d, actual %0d",
                     $time, want.value, got.value);
            errors++;
          end
          if (got.hit !== want.hit) begin
            $display("%0t: in_range mismatch: expected %0b, actual %0b",
                     $time, want.hit, got.hit);
            errors++;
          end
        end
      end
      if (cfg_we) begin
        if (cfg_index == CFG_X_POINTS) x_count = cfg_data;
        else y_count = cfg_data;
      end
      if (start && !busy) begin
        case (kind_t'(kind))
          KIND_LOAD_X: x_pts[grid_index] = longint'(load_value);
          KIND_LOAD_Y: y_pts[grid_index] = longint'(load_value);
          KIND_LOAD_Z: z_tab[table_row*MAX_X + table_col] = longint'(load_value);
          default:     interp_q = {interp_q, interpolate(longint'(query_x), longint'(query_y))};
        endcase
      end
    end
    pending <= interp_q.size();
  end

endmodule

### tb/sv/tb_grid_bilinear_interpolator_top.sv
// Testbench top: stimulus, configuration phases and verdict for the interpolator.
`timescale 1ns / 100ps

module tb_grid_bilinear_interpolator_top;
  import gbi_pkg::*;

  localparam longint VMAX     = 64'sd2147483647;
  localparam longint VMIN     = -64'sd2147483648;
  localparam int     WD_LIMIT = 20000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         kind = '0;
  logic [5:0]         grid_index = '0;
  logic [5:0]         table_row = '0;
  logic [5:0]         table_col = '0;
  logic signed [31:0] load_value = '0;
  logic signed [31:0] query_x = '0;
  logic signed [31:0] query_y = '0;
  logic               cfg_we = 1'b0;
  logic               cfg_index = 1'b0;
  logic [6:0]         cfg_data = '0;
  logic               done;
  logic signed [31:0] result_value;
  logic               in_range;
  int                 errors;
  int                 pending;
  int                 stall_cycles = 0;
  int                 gap_pct = 0;

  // Stimulus-side copy of the grids and of which table entries hold data.
  longint gx[MAX_X];
  longint gy[MAX_Y];
  bit     z_loaded[MAX_X*MAX_Y];
  int     nx, ny;

  grid_bilinear_interpolator_top u_top (.*);

  gbi_checker u_checker (.*);

  initial forever #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WD_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic longint rnd64(longint span);
    return longint'({$urandom, $urandom} & 64'h7FFF_FFFF_FFFF_FFFF) % span;
  endfunction

  task automatic send(kind_t k, int gi, int row, int col, longint lv, longint qx,
                      longint qy);
    if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start      <= 1'b1;
    kind       <= k;
    grid_index <= gi[5:0];
    table_row  <= row[5:0];
    table_col  <= col[5:0];
    load_value <= lv[31:0];
    query_x    <= qx[31:0];
    query_y    <= qy[31:0];
    do @(posedge clk); while (busy);
  endtask

  task automatic load_z(int row, int col, longint v);
    z_loaded[row*MAX_X + col] = 1'b1;
    send(KIND_LOAD_Z, $urandom, row, col, v, $urandom, $urandom);
  endtask

  task automatic query(longint qx, longint qy);
    send(KIND_QUERY, $urandom, $urandom, $urandom, $urandom, qx, qy);
  endtask

  // Loads that land in the queue may still be running when the last result comes.
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [6:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(logic [6:0] xc, logic [6:0] yc);
    write_cfg(CFG_X_POINTS, xc);
    write_cfg(CFG_Y_POINTS, yc);
    nx = (xc < 2) ? 2 : (xc > MAX_X) ? MAX_X : int'(xc);
    ny = (yc < 2) ? 2 : (yc > MAX_Y) ? MAX_Y : int'(yc);
  endtask

  // Loads both grids; sorted grids are strictly monotonic so a cell can be aimed at.
  task automatic build_grids(int mode);
    longint step;
    step = (mode == 1) ? 100 : 64'd4294960000 / nx;
    for (int i = 0; i < nx; i++) begin
      if (mode == 2) gx[i] = longint'($urandom_range(20)) * 65536 - 10 * 65536;
      else if (i == 0) gx[i] = VMIN + longint'($urandom_range(1000));
      else gx[i] = gx[i-1] + 1 + rnd64(step);
      send(KIND_LOAD_X, i, $urandom, $urandom, gx[i], $urandom, $urandom);
    end
    step = (mode == 1) ? 100 : 64'd4294960000 / ny;
    for (int i = 0; i < ny; i++) begin
      if (mode == 2) gy[i] = longint'($urandom_range(20)) * 65536 - 10 * 65536;
      else if (i == 0) gy[i] = VMAX - longint'($urandom_range(1000));
      else gy[i] = gy[i-1] - 1 - rnd64(step);
      send(KIND_LOAD_Y, i, $urandom, $urandom, gy[i], $urandom, $urandom);
    end
  endtask

  task automatic cell_query();
    int     ix, iy;
    longint qx, qy;
    ix = $urandom_range(nx - 2);
    iy = $urandom_range(ny - 2);
    for (int r = iy; r <= iy + 1; r++)
      for (int c = ix; c <= ix + 1; c++)
        if (!z_loaded[r*MAX_X + c]) load_z(r, c, longint'(signed'($urandom)));
    qx = ($urandom_range(9) == 0) ? gx[ix] : gx[ix] + rnd64(gx[ix+1] - gx[ix]);
    qy = gy[iy] - 1 - rnd64(gy[iy] - gy[iy+1]);
    query(qx, qy);
  endtask

  task automatic run_phase(logic [6:0] xc, logic [6:0] yc, int gap, int mode, int items);
    int     pick;
    longint qx;
    settle();
    configure(xc, yc);
    gap_pct = gap;
    build_grids(mode);
    if (mode == 2)
      for (int r = 0; r < ny; r++)
        for (int c = 0; c < nx; c++) load_z(r, c, longint'(signed'($urandom)));
    for (int n = 0; n < items; n++) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        if (nx < MAX_X && pick < 4)
          send(KIND_LOAD_X, $urandom_range(MAX_X - 1, nx), 0, 0, $urandom, 0, 0);
        else if (ny < MAX_Y && pick < 7)
          send(KIND_LOAD_Y, $urandom_range(MAX_Y - 1, ny), 0, 0, $urandom, 0, 0);
        else
          load_z($urandom_range(63), $urandom_range(63), longint'(signed'($urandom)));
      end else if (mode == 2) begin
        if (pick < 30) query(longint'(signed'($urandom)), longint'(signed'($urandom)));
        else query(longint'($urandom_range(24 * 65536)) - 12 * 65536,
                   longint'($urandom_range(24 * 65536)) - 12 * 65536);
      end else if (pick < 25) begin
        // The x coordinate lies at or past the last grid point, so the query is reported out of range.
        qx = gx[nx-1] + longint'($urandom_range(1000));
        query((qx > VMAX) ? VMAX : qx, longint'(signed'($urandom)));
      end else begin
        cell_query();
      end
    end
  endtask

  initial begin
    foreach (z_loaded[i]) z_loaded[i] = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Smallest grid spanning the whole value range, corners at the extremes.
    configure(7'd0, 7'd1);
    gx[0] = VMIN;  gx[1] = VMAX;
    gy[0] = VMAX;  gy[1] = VMIN;
    send(KIND_LOAD_X, 0, 0, 0, gx[0], 0, 0);
    send(KIND_LOAD_X, 1, 0, 0, gx[1], 0, 0);
    send(KIND_LOAD_Y, 0, 0, 0, gy[0], 0, 0);
    send(KIND_LOAD_Y, 1, 0, 0, gy[1], 0, 0);
    load_z(0, 0, VMAX);
    load_z(0, 1, VMIN);
    load_z(1, 0, VMIN);
    load_z(1, 1, VMAX);
    load_z(63, 63, -1);
    query(VMIN, VMAX - 1);
    query(0, 0);
    query(-1, -1);
    query(VMAX - 1, VMIN);
    query(VMAX, 0);
    query(0, VMAX);
    query(VMIN, VMIN);

    run_phase(7'd3, 7'd5, 0, 0, 30);
    run_phase(7'd8, 7'd4, 73, 1, 30);
    run_phase(7'd127, 7'd127, 0, 0, 30);
    run_phase(7'd5, 7'd6, 26, 2, 30);
    run_phase(7'd64, 7'd2, 73, 0, 30);
    run_phase(7'd2, 7'd64, 26, 1, 30);
    run_phase(7'd7, 7'd9, 0, 2, 30);

    settle();
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
